/* sv/ptb_pkg.sv */
package ptb_pkg;

   localparam int unsigned TIME_W  = 32;
   localparam int unsigned TAG_W   = 16;
   localparam int unsigned COUNT_W = 16;
   localparam int unsigned ID_W    = 4;

   localparam logic [COUNT_W-1:0] COUNT_ENDLESS = '1;

   typedef enum logic [1:0] {
      ACT_SET  = 2'd0,
      ACT_KILL = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_WALK = 2'b10
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0]  period;
      logic [TIME_W-1:0]  mark;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] count;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0]    slot;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] remaining;
      logic               stopped;
   } event_type;

endpackage

/* sv/ptb_table.sv */
module ptb_table
   import ptb_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  entry_type     wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output entry_type     rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/periodic_timer_bank_unit.sv */
// channel | dir | handshake            | beat
// req_    | in  | req_valid/req_ready  | set, kill or tick with slot fields and time
// rsp_    | out | rsp_valid/rsp_ready  | one fired slot event
//
// set and kill complete while idle; a tick walks the slots in ST_WALK,
// one slot per cycle unless stalled, read from the registered slot table.
// each event is held one step so the final one of a tick carries last_event.
// a busy result register stalls the walk only when a second event is due.
// synchronous reset clears the enable bits and the control state.
module periodic_timer_bank_unit
   import ptb_pkg::*;
#(
   parameter int unsigned NUM_SLOTS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [ID_W-1:0]     req_slot_id,
   input  logic [TIME_W-1:0]   req_period_ticks,
   input  logic [TAG_W-1:0]    req_owner_tag,
   input  logic [COUNT_W-1:0]  req_repeat_count,
   input  logic [TIME_W-1:0]   req_now_time,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [ID_W-1:0]     rsp_fired_slot,
   output logic [TAG_W-1:0]    rsp_fired_tag,
   output logic [COUNT_W-1:0]  rsp_remaining,
   output logic                rsp_stopped,
   output logic                rsp_last_event
);

   localparam int unsigned SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int unsigned CNT_W  = $clog2(NUM_SLOTS + 1);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(NUM_SLOTS);

   state_type             state_ff, state_in;
   logic [NUM_SLOTS-1:0]  en_ff, en_in;
   logic [CNT_W-1:0]      scan_ff, scan_in;
   logic                  eval_valid_ff, eval_valid_in;
   logic [SLOT_W-1:0]     eval_slot_ff, eval_slot_in;
   logic [TIME_W-1:0]     now_ff, now_in;
   logic                  hold_valid_ff, hold_valid_in;
   event_type             hold_ff, hold_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   event_type             out_ff, out_in;
   logic                  last_ff, last_in;

   logic                  accept;
   action_type            act;
   logic                  id_ok;
   logic                  walk;
   logic                  out_free;
   logic                  fire;
   logic                  stall;
   logic                  done;
   logic                  more;
   logic [TIME_W-1:0]     elapsed;
   logic [COUNT_W-1:0]    new_count;
   logic                  stop;

   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   entry_type             wr_data;
   logic                  rd_en;
   entry_type             rd_data;

   ptb_table #(
      .DEPTH (NUM_SLOTS),
      .AW    (SLOT_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   assign accept    = req_valid && req_ready;
   assign act       = action_type'(req_action);
   assign id_ok     = 32'(req_slot_id) < NUM_SLOTS;
   assign walk      = (state_ff == ST_WALK);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign elapsed   = now_ff - rd_data.mark;
   assign fire      = walk && eval_valid_ff && en_ff[eval_slot_ff]
                      && (elapsed >= rd_data.period);
   assign stall     = fire && hold_valid_ff && !out_free;
   assign more      = scan_ff < LAST_CNT;
   assign done      = !more && !eval_valid_ff;
   assign new_count = (rd_data.count == COUNT_ENDLESS) ? rd_data.count
                      : rd_data.count - COUNT_W'(1);
   assign stop      = (new_count == '0);
   assign rd_en     = walk && !stall && more;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = eval_slot_ff;
      wr_data = rd_data;
      if (accept && act == ACT_SET && id_ok) begin
         wr_en        = 1'b1;
         wr_addr      = SLOT_W'(req_slot_id);
         wr_data      = '{period: req_period_ticks, mark: req_now_time,
                          tag: req_owner_tag, count: req_repeat_count};
      end else if (fire && !stall) begin
         wr_en        = 1'b1;
         wr_data.mark = rd_data.mark + rd_data.period;
         wr_data.count = new_count;
      end
   end

   always_comb begin
      state_in      = state_ff;
      en_in         = en_ff;
      scan_in       = scan_ff;
      eval_valid_in = eval_valid_ff;
      eval_slot_in  = eval_slot_ff;
      now_in        = now_ff;
      hold_valid_in = hold_valid_ff;
      hold_in       = hold_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      out_in        = out_ff;
      last_in       = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (act)
                  ACT_SET: begin
                     if (id_ok) begin
                        en_in[SLOT_W'(req_slot_id)] = 1'b1;
                     end
                  end
                  ACT_KILL: begin
                     if (id_ok) begin
                        en_in[SLOT_W'(req_slot_id)] = 1'b0;
                     end
                  end
                  ACT_TICK: begin
                     state_in      = ST_WALK;
                     scan_in       = '0;
                     eval_valid_in = 1'b0;
                     now_in        = req_now_time;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (!stall) begin
               eval_valid_in = more;
               eval_slot_in  = scan_ff[SLOT_W-1:0];
               if (more) begin
                  scan_in = scan_ff + CNT_W'(1);
               end
            end
            if (fire && !stall) begin
               if (stop) begin
                  en_in[eval_slot_ff] = 1'b0;
               end
               if (hold_valid_ff) begin
                  rsp_valid_in = 1'b1;
                  out_in       = hold_ff;
                  last_in      = 1'b0;
               end
               hold_valid_in = 1'b1;
               hold_in       = '{slot: ID_W'(eval_slot_ff), tag: rd_data.tag,
                                 remaining: new_count, stopped: stop};
            end
            if (done) begin
               if (!hold_valid_ff) begin
                  state_in = ST_IDLE;
               end else if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  out_in        = hold_ff;
                  last_in       = 1'b1;
                  hold_valid_in = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         en_ff         <= '0;
         scan_ff       <= '0;
         eval_valid_ff <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         en_ff         <= en_in;
         scan_ff       <= scan_in;
         eval_valid_ff <= eval_valid_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_slot_ff <= eval_slot_in;
      now_ff       <= now_in;
      hold_ff      <= hold_in;
      out_ff       <= out_in;
      last_ff      <= last_in;
   end

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_fired_slot = out_ff.slot;
   assign rsp_fired_tag  = out_ff.tag;
   assign rsp_remaining  = out_ff.remaining;
   assign rsp_stopped    = out_ff.stopped;
   assign rsp_last_event = last_ff;

endmodule
